### src/grid_local_minimum_detector_assert.svh
// Assertion macros used by the detector's RTL (its emit stage includes them).
// Both expect i_clk and active-low i_rst_n in scope.
`ifndef GRID_LOCAL_MINIMUM_DETECTOR_ASSERT_SVH
`define GRID_LOCAL_MINIMUM_DETECTOR_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define GLMD_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define GLMD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/glmd_pkg.sv
package glmd_pkg;

    localparam int HEIGHT_W = 4;
    localparam int COORD_W  = 7;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam int CFG_W    = 8;
    localparam int NUM_SLOTS = 3;

    typedef logic [HEIGHT_W-1:0] t_height;
    typedef logic [COORD_W-1:0]  t_coord;
    typedef logic [CFG_W-1:0]    t_cfg;

    localparam t_height BORDER_HEIGHT = 4'd10;
    localparam t_cfg    GRID_COLS_RESET = 8'd100;
    localparam t_cfg    GRID_ROWS_RESET = 8'd100;

    typedef enum logic {
        REG_GRID_COLS = 1'b0,
        REG_GRID_ROWS = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_coord  cell_row;
        t_coord  cell_col;
        t_height cell_height;
        logic    is_low;
        logic    run_end;
        logic    frame_end;
    } t_result;

    function automatic logic below_all(input t_height self, input t_height left,
                                       input t_height right, input t_height up,
                                       input t_height down);
        return (self < left) && (self < right) && (self < up) && (self < down);
    endfunction

endpackage

### src/glmd_if.sv
interface glmd_in_if;
    import glmd_pkg::*;

    logic    valid;
    logic    ready;
    t_height height;

    modport source (output valid, output height, input ready);
    modport sink   (input valid, input height, output ready);
endinterface

interface glmd_out_if;
    import glmd_pkg::*;

    logic    valid;
    logic    ready;
    t_coord  cell_row;
    t_coord  cell_col;
    t_height cell_height;
    logic    is_low;
    logic    run_end;
    logic    frame_end;

    modport source (output valid, output cell_row, output cell_col, output cell_height,
                    output is_low, output run_end, output frame_end, input ready);
    modport sink   (input valid, input cell_row, input cell_col, input cell_height,
                    input is_low, input run_end, input frame_end, output ready);
endinterface

### src/glmd_line_bank.sv
module glmd_line_bank #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  glmd_pkg::t_height     i_wdata,
    input  logic                  i_re,
    input  logic [AW-1:0]         i_raddr_a,
    input  logic [AW-1:0]         i_raddr_b,
    output glmd_pkg::t_height     o_rdata_a,
    output glmd_pkg::t_height     o_rdata_b
);
    import glmd_pkg::*;

    t_height r_mem [DEPTH];
    t_height r_rd_a;
    t_height r_rd_b;

    // read data holds between enables; a same-address write returns the old value
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_a <= r_mem[i_raddr_a];
            r_rd_b <= r_mem[i_raddr_b];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

### src/glmd_cfg.sv
module glmd_cfg #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 128,
    parameter int CNTW     = 8,
    parameter int RCNTW    = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [glmd_pkg::APB_AW-1:0]  i_paddr,
    input  logic [glmd_pkg::APB_DW-1:0]  i_pwdata,
    output logic [glmd_pkg::APB_DW-1:0]  o_prdata,
    output logic [CNTW-1:0]              o_cols,
    output logic [RCNTW-1:0]             o_rows
);
    import glmd_pkg::*;

    t_cfg r_grid_cols;
    t_cfg r_grid_rows;
    t_cfg n_grid_cols;
    t_cfg n_grid_rows;
    logic [CNTW-1:0]  r_cols_lim;
    logic [RCNTW-1:0] r_rows_lim;
    logic             wr_en;
    t_reg_idx         reg_idx;

    function automatic logic [CNTW-1:0] lim_cols(input t_cfg v);
        logic [CNTW-1:0] res;
        if (v == '0) begin
            res = CNTW'(1);
        end else if (32'(v) > 32'(MAX_COLS)) begin
            res = CNTW'(MAX_COLS);
        end else begin
            res = CNTW'(v);
        end
        return res;
    endfunction

    function automatic logic [RCNTW-1:0] lim_rows(input t_cfg v);
        logic [RCNTW-1:0] res;
        if (v == '0) begin
            res = RCNTW'(1);
        end else if (32'(v) > 32'(MAX_ROWS)) begin
            res = RCNTW'(MAX_ROWS);
        end else begin
            res = RCNTW'(v);
        end
        return res;
    endfunction

    assign wr_en   = i_psel && i_penable && i_pwrite;
    assign reg_idx = t_reg_idx'(i_paddr[2]);

    always_comb begin
        n_grid_cols = r_grid_cols;
        n_grid_rows = r_grid_rows;
        if (wr_en) begin
            case (reg_idx)
                REG_GRID_COLS: n_grid_cols = i_pwdata[CFG_W-1:0];
                REG_GRID_ROWS: n_grid_rows = i_pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_GRID_COLS: o_prdata = APB_DW'(r_grid_cols);
            REG_GRID_ROWS: o_prdata = APB_DW'(r_grid_rows);
            default:       o_prdata = '0;
        endcase
    end

    // limited sizes kept in flops so the position compare sees no clamp logic
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols <= GRID_COLS_RESET;
            r_grid_rows <= GRID_ROWS_RESET;
            r_cols_lim  <= lim_cols(GRID_COLS_RESET);
            r_rows_lim  <= lim_rows(GRID_ROWS_RESET);
        end else begin
            r_grid_cols <= n_grid_cols;
            r_grid_rows <= n_grid_rows;
            r_cols_lim  <= lim_cols(n_grid_cols);
            r_rows_lim  <= lim_rows(n_grid_rows);
        end
    end

    assign o_cols = r_cols_lim;
    assign o_rows = r_rows_lim;

endmodule

### src/glmd_emit.sv
`include "grid_local_minimum_detector_assert.svh"

module glmd_emit (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_item_valid,
    input  glmd_pkg::t_result [glmd_pkg::NUM_SLOTS-1:0] i_items,
    input  logic [glmd_pkg::NUM_SLOTS-1:0]              i_mask,
    output logic                                        o_item_done,
    output logic                                        o_valid,
    output glmd_pkg::t_result                           o_result,
    input  logic                                        i_ready
);
    import glmd_pkg::*;

    logic [NUM_SLOTS-1:0] r_sent;
    logic [NUM_SLOTS-1:0] n_sent;
    logic [NUM_SLOTS-1:0] remaining;
    logic [NUM_SLOTS-1:0] sel_bit;
    logic [NUM_SLOTS-1:0] after;
    logic [1:0]           sel;
    logic                 out_free;
    logic                 load;
    logic                 r_o_valid;
    logic                 n_o_valid;
    t_result              r_o_res;
    t_result              n_o_res;

    always_comb begin
        remaining = i_mask & ~r_sent;
        if (remaining[0]) begin
            sel = 2'd0;
        end else if (remaining[1]) begin
            sel = 2'd1;
        end else begin
            sel = 2'd2;
        end
        sel_bit  = NUM_SLOTS'(1) << sel;
        after    = remaining & ~sel_bit;
        out_free = !r_o_valid || i_ready;
        load     = i_item_valid && (remaining != '0) && out_free;
        // an item with no results is dropped at once
        o_item_done = i_item_valid && ((remaining == '0) || (load && (after == '0)));

        n_sent = r_sent;
        if (o_item_done) begin
            n_sent = '0;
        end else if (load) begin
            n_sent = r_sent | sel_bit;
        end

        n_o_valid = r_o_valid;
        if (load) begin
            n_o_valid = 1'b1;
        end else if (i_ready) begin
            n_o_valid = 1'b0;
        end

        n_o_res = r_o_res;
        if (load) begin
            n_o_res         = i_items[sel];
            n_o_res.run_end = (after == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_sent    <= n_sent;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_res <= n_o_res;
    end

    assign o_valid  = r_o_valid;
    assign o_result = r_o_res;

    `GLMD_ASSERT(a_sent_in_mask, !i_item_valid || ((r_sent & ~i_mask) == '0), "slot sent that the item does not have")
    `GLMD_ASSERT_NEXT(a_done_clears, o_item_done, r_sent == '0, "sent mask not cleared after item")
    `GLMD_ASSERT_NEXT(a_load_shows, load, r_o_valid, "loaded word not presented")
    `GLMD_ASSERT(a_frame_is_last, !r_o_valid || !r_o_res.frame_end || r_o_res.run_end, "frame end without run end")

endmodule

### src/grid_local_minimum_detector.sv
// Streaming 4-neighbour local minimum detector. Heights arrive in raster order on i_in, one
// word per cycle while i_in.ready is high; each cell is reported on o_out with its row,
// column, height and a flag set when it is strictly below its left, right, upper and lower
// neighbours (off-grid neighbours count as 10). Inner-row cells are reported when the cell
// below arrives, passing through the r_s1 stage and the output register. Outside the final
// row a height gives at most one result; in the final row a height gives up to two results
// (three on the last cell) and, with one result word leaving per cycle while o_out.ready is
// high, a new height is taken only once the last result of the one before is loaded.
// History is two line banks of MAX_COLS heights, each with one write and two reads per cycle;
// their contents are undefined after reset and need no clearing. grid_cols and grid_rows
// (APB, byte addresses 0 and 4) are limited to 1..MAX_COLS and 1..MAX_ROWS.
module grid_local_minimum_detector #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 128
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [glmd_pkg::APB_AW-1:0]  paddr,
    input  logic [glmd_pkg::APB_DW-1:0]  pwdata,
    output logic [glmd_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    glmd_in_if.sink                      i_in,
    glmd_out_if.source                   o_out
);
    import glmd_pkg::*;

    localparam int CW    = $clog2(MAX_COLS);
    localparam int CNTW  = $clog2(MAX_COLS + 1);
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RCNTW = $clog2(MAX_ROWS + 1);

    typedef struct packed {
        t_height         h;
        logic [RW-1:0]   row;
        logic [CW-1:0]   col;
        logic            pb;
        logic            r_gt0;
        logic            r_gt1;
        logic            c_gt0;
        logic            c_gt1;
        logic            c_last;
        logic            r_last;
        t_height         prev_h;
        t_height         prev2_h;
        t_height         p_left;
    } t_stage;

    logic [CNTW-1:0]  cols;
    logic [RCNTW-1:0] rows;

    logic [RW-1:0] r_row;
    logic [RW-1:0] n_row;
    logic [CW-1:0] r_col;
    logic [CW-1:0] n_col;
    logic          r_bank;
    logic          n_bank;
    t_height       r_prev_h;
    t_height       r_prev2_h;
    logic          r_s1_valid;
    t_stage        r_s1;
    t_stage        n_s1;

    logic          accept;
    logic          in_ready;
    logic          restart;
    logic [RW-1:0] eff_r;
    logic [CW-1:0] eff_c;
    logic          c_last;
    logic          r_last;
    logic [CW-1:0] addr_next;

    t_height rd0_a;
    t_height rd0_b;
    t_height rd1_a;
    t_height rd1_b;
    t_height p_c;
    t_height p_r;
    t_height q_c;
    t_height left_a;
    t_height right_a;
    t_height up_a;
    t_height left_b;
    t_height up_b;
    t_height left_c;
    t_height up_c;

    t_result [NUM_SLOTS-1:0] items;
    logic [NUM_SLOTS-1:0]    mask;
    logic                    item_done;
    logic                    out_valid;
    t_result                 out_res;

    glmd_cfg #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .CNTW     (CNTW),
        .RCNTW    (RCNTW)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cols    (cols),
        .o_rows    (rows)
    );

    assign pready = 1'b1;

    // position of this word; a size change that leaves it off the grid starts a new grid
    always_comb begin
        restart   = (CNTW'(r_col) >= cols) || (RCNTW'(r_row) >= rows);
        eff_r     = restart ? '0 : r_row;
        eff_c     = restart ? '0 : r_col;
        c_last    = (CNTW'(eff_c) + CNTW'(1)) == cols;
        r_last    = (RCNTW'(eff_r) + RCNTW'(1)) == rows;
        addr_next = CW'(eff_c + CW'(1));

        n_row  = r_row;
        n_col  = r_col;
        n_bank = r_bank;
        if (accept) begin
            if (c_last) begin
                n_col  = '0;
                n_bank = ~r_bank;
                n_row  = r_last ? '0 : RW'(eff_r + RW'(1));
            end else begin
                n_col = addr_next;
                n_row = eff_r;
            end
        end
    end

    assign in_ready   = !r_s1_valid || item_done;
    assign accept     = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    // r_bank names the bank with the previous row; the current row goes to the other one
    glmd_line_bank #(
        .DEPTH (MAX_COLS),
        .AW    (CW)
    ) u_bank0 (
        .i_clk     (i_clk),
        .i_we      (accept && r_bank),
        .i_waddr   (eff_c),
        .i_wdata   (i_in.height),
        .i_re      (accept),
        .i_raddr_a (eff_c),
        .i_raddr_b (addr_next),
        .o_rdata_a (rd0_a),
        .o_rdata_b (rd0_b)
    );

    glmd_line_bank #(
        .DEPTH (MAX_COLS),
        .AW    (CW)
    ) u_bank1 (
        .i_clk     (i_clk),
        .i_we      (accept && !r_bank),
        .i_waddr   (eff_c),
        .i_wdata   (i_in.height),
        .i_re      (accept),
        .i_raddr_a (eff_c),
        .i_raddr_b (addr_next),
        .o_rdata_a (rd1_a),
        .o_rdata_b (rd1_b)
    );

    always_comb begin
        n_s1        = r_s1;
        n_s1.h      = i_in.height;
        n_s1.row    = eff_r;
        n_s1.col    = eff_c;
        n_s1.pb     = r_bank;
        n_s1.r_gt0  = eff_r != '0;
        n_s1.r_gt1  = eff_r > RW'(1);
        n_s1.c_gt0  = eff_c != '0;
        n_s1.c_gt1  = eff_c > CW'(1);
        n_s1.c_last = c_last;
        n_s1.r_last = r_last;
        n_s1.prev_h  = r_prev_h;
        n_s1.prev2_h = r_prev2_h;
        // upper-row height one column back, as read for the word before
        n_s1.p_left  = r_s1.pb ? rd1_a : rd0_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_bank     <= 1'b0;
            r_prev_h   <= '0;
            r_prev2_h  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_bank <= n_bank;
            if (accept) begin
                r_prev_h   <= i_in.height;
                r_prev2_h  <= r_prev_h;
                r_s1_valid <= 1'b1;
            end else if (item_done) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    // slot 0: cell above; slot 1: cell to the left (final row); slot 2: this cell
    always_comb begin
        p_c = r_s1.pb ? rd1_a : rd0_a;
        p_r = r_s1.pb ? rd1_b : rd0_b;
        q_c = r_s1.pb ? rd0_a : rd1_a;

        left_a  = r_s1.c_gt0  ? r_s1.p_left  : BORDER_HEIGHT;
        right_a = r_s1.c_last ? BORDER_HEIGHT : p_r;
        up_a    = r_s1.r_gt1  ? q_c           : BORDER_HEIGHT;
        left_b  = r_s1.c_gt1  ? r_s1.prev2_h  : BORDER_HEIGHT;
        up_b    = r_s1.r_gt0  ? r_s1.p_left   : BORDER_HEIGHT;
        left_c  = r_s1.c_gt0  ? r_s1.prev_h   : BORDER_HEIGHT;
        up_c    = r_s1.r_gt0  ? p_c           : BORDER_HEIGHT;

        items[0].cell_row    = t_coord'(RW'(r_s1.row - RW'(1)));
        items[0].cell_col    = t_coord'(r_s1.col);
        items[0].cell_height = p_c;
        items[0].is_low      = below_all(p_c, left_a, right_a, up_a, r_s1.h);
        items[0].run_end     = 1'b0;
        items[0].frame_end   = 1'b0;

        items[1].cell_row    = t_coord'(r_s1.row);
        items[1].cell_col    = t_coord'(CW'(r_s1.col - CW'(1)));
        items[1].cell_height = r_s1.prev_h;
        items[1].is_low      = below_all(r_s1.prev_h, left_b, r_s1.h, up_b, BORDER_HEIGHT);
        items[1].run_end     = 1'b0;
        items[1].frame_end   = 1'b0;

        items[2].cell_row    = t_coord'(r_s1.row);
        items[2].cell_col    = t_coord'(r_s1.col);
        items[2].cell_height = r_s1.h;
        items[2].is_low      = below_all(r_s1.h, left_c, BORDER_HEIGHT, up_c, BORDER_HEIGHT);
        items[2].run_end     = 1'b0;
        items[2].frame_end   = 1'b1;

        mask = {r_s1.r_last && r_s1.c_last, r_s1.r_last && r_s1.c_gt0, r_s1.r_gt0};
    end

    glmd_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (r_s1_valid),
        .i_items      (items),
        .i_mask       (mask),
        .o_item_done  (item_done),
        .o_valid      (out_valid),
        .o_result     (out_res),
        .i_ready      (o_out.ready)
    );

    assign o_out.valid       = out_valid;
    assign o_out.cell_row    = out_res.cell_row;
    assign o_out.cell_col    = out_res.cell_col;
    assign o_out.cell_height = out_res.cell_height;
    assign o_out.is_low      = out_res.is_low;
    assign o_out.run_end     = out_res.run_end;
    assign o_out.frame_end   = out_res.frame_end;

endmodule
